// File: hdl/bds_pkg.sv
// Shared types and constants for the button debounce scanner.
package bds_pkg;

    typedef logic [15:0] delay_t;
    typedef logic [3:0]  buttons_t;

    // Register indexes on the configuration port (byte address = 4 * index).
    typedef enum logic [1:0] {
        REG_SHORT_DELAY      = 2'd0,
        REG_MENU_HOLD_DELAY  = 2'd1,
        REG_RESET_HOLD_DELAY = 2'd2,
        REG_UNUSED           = 2'd3
    } reg_index_t;

    localparam buttons_t MASK_ALL   = 4'hF;
    localparam buttons_t MASK_COMBO = 4'h9;
    localparam buttons_t MASK_MENU  = 4'h1;
    localparam buttons_t ESC_ONLY   = 4'h8;
    localparam logic [4:0] NO_SAMPLE = 5'h1F;

    localparam delay_t SHORT_DELAY_RESET      = 16'd20;
    localparam delay_t MENU_HOLD_DELAY_RESET  = 16'd1000;
    localparam delay_t RESET_HOLD_DELAY_RESET = 16'd5000;
    localparam delay_t DELAY_ZERO             = 16'd0;
    localparam delay_t DELAY_ONE              = 16'd1;

endpackage

// File: hdl/button_debounce_scanner.sv
// Button debounce scanner: menu-mode pattern debounce and long-press detection.
//
//  Channel | Dir    | Ports                                                       | Beat
//  --------+--------+-------------------------------------------------------------+----------------
//  s_      | in     | s_valid, s_ready, s_pressed, s_menu_active                  | tick sample
//  m_      | out    | m_valid, m_ready, m_debounced, m_button_state, m_changed_bits | tick result
//  apb     | config | psel, penable, pwrite, paddr, pwdata, prdata, pready        | register access
//
// Each tick beat is processed combinationally; one beat per clock is sustained while m_ready is high.
// The result appears in the cycle after acceptance, held in the output register.
// s_ready is high whenever the output register is empty or is being drained.
// Reset (synchronous, aresetn low) restores the delay registers and all state.
module button_debounce_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_pressed,
    input  logic        s_menu_active,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_debounced,
    output logic [3:0]  m_button_state,
    output logic [3:0]  m_changed_bits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bds_pkg::delay_t   short_delay_reg;
    bds_pkg::delay_t   menu_hold_delay_reg;
    bds_pkg::delay_t   reset_hold_delay_reg;

    logic [4:0]        last_sample_reg;
    bds_pkg::delay_t   hold_count_reg;
    logic              combo_armed_reg;
    bds_pkg::buttons_t stable_buttons_reg;
    bds_pkg::buttons_t change_mask_reg;
    logic              m_valid_reg;
    logic              m_debounced_reg;

    logic [4:0]        last_sample_next;
    bds_pkg::delay_t   hold_count_next;
    logic              combo_armed_next;
    bds_pkg::buttons_t stable_buttons_next;
    bds_pkg::buttons_t change_mask_next;
    logic              report_next;

    bds_pkg::reg_index_t reg_sel;
    bds_pkg::delay_t     hold_dec;
    logic                s_accept;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = bds_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = 32'd0;
        case (reg_sel)
            bds_pkg::REG_SHORT_DELAY:      prdata = {16'd0, short_delay_reg};
            bds_pkg::REG_MENU_HOLD_DELAY:  prdata = {16'd0, menu_hold_delay_reg};
            bds_pkg::REG_RESET_HOLD_DELAY: prdata = {16'd0, reset_hold_delay_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_delay_reg      <= bds_pkg::SHORT_DELAY_RESET;
            menu_hold_delay_reg  <= bds_pkg::MENU_HOLD_DELAY_RESET;
            reset_hold_delay_reg <= bds_pkg::RESET_HOLD_DELAY_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                bds_pkg::REG_SHORT_DELAY:      short_delay_reg      <= pwdata[15:0];
                bds_pkg::REG_MENU_HOLD_DELAY:  menu_hold_delay_reg  <= pwdata[15:0];
                bds_pkg::REG_RESET_HOLD_DELAY: reset_hold_delay_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign hold_dec = hold_count_reg - bds_pkg::DELAY_ONE;

    // The hold counter is shared by both modes and only reloads on a new pattern
    // (menu mode) or on a release of the menu button (long-press mode).
    always_comb begin
        hold_count_next     = hold_count_reg;
        combo_armed_next    = combo_armed_reg;
        stable_buttons_next = stable_buttons_reg;
        change_mask_next    = change_mask_reg;
        report_next         = 1'b0;
        last_sample_next    = {1'b0, s_pressed};

        if (s_menu_active) begin
            combo_armed_next = 1'b0;
            if ({1'b0, s_pressed} != last_sample_reg) begin
                hold_count_next = short_delay_reg;
            end else if (hold_count_reg != bds_pkg::DELAY_ZERO) begin
                hold_count_next = hold_dec;
                if (hold_dec == bds_pkg::DELAY_ZERO) begin
                    report_next         = 1'b1;
                    change_mask_next    = (s_pressed ^ stable_buttons_reg) & bds_pkg::MASK_ALL;
                    stable_buttons_next = s_pressed;
                end
            end
        end else if ((s_pressed & bds_pkg::MASK_MENU) != 4'd0) begin
            if (hold_count_reg != bds_pkg::DELAY_ZERO) begin
                hold_count_next = hold_dec;
                if (hold_dec == bds_pkg::DELAY_ZERO) begin
                    report_next         = 1'b1;
                    stable_buttons_next = s_pressed & (combo_armed_reg ? bds_pkg::MASK_COMBO
                                                                       : bds_pkg::MASK_MENU);
                    change_mask_next    = stable_buttons_next;
                end
            end
        end else if (s_pressed == bds_pkg::ESC_ONLY) begin
            hold_count_next  = reset_hold_delay_reg;
            combo_armed_next = 1'b1;
        end else begin
            hold_count_next  = menu_hold_delay_reg;
            combo_armed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg    <= bds_pkg::NO_SAMPLE;
            hold_count_reg     <= bds_pkg::SHORT_DELAY_RESET;
            combo_armed_reg    <= 1'b0;
            stable_buttons_reg <= 4'd0;
            change_mask_reg    <= 4'd0;
            m_valid_reg        <= 1'b0;
            m_debounced_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                last_sample_reg    <= last_sample_next;
                hold_count_reg     <= hold_count_next;
                combo_armed_reg    <= combo_armed_next;
                stable_buttons_reg <= stable_buttons_next;
                change_mask_reg    <= change_mask_next;
                m_debounced_reg    <= report_next;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // State only moves on an accepted beat, so the held result can read it directly.
    assign m_valid        = m_valid_reg;
    assign m_debounced    = m_debounced_reg;
    assign m_button_state = stable_buttons_reg;
    assign m_changed_bits = change_mask_reg;

    a_report_leaves_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_debounced) |-> (hold_count_reg == bds_pkg::DELAY_ZERO))
        else $error("report held while hold counter is nonzero");

    a_menu_clears_combo: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_menu_active) |=> !combo_armed_reg)
        else $error("combo stayed armed after a menu-mode beat");

    a_long_press_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_menu_active && report_next) |=> (m_button_state == m_changed_bits))
        else $error("long-press report with mismatched state and change bits");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled while output register is empty");

endmodule
